// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the stretch blit blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SBAG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbag assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SBAG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbag assertion failed");

`endif

// ===== sv/sbag_pkg.sv =====
// ----------------------------------------------------------------------------
// sbag_pkg
// Types, register codes and helpers shared by the stretch blit address blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package sbag_pkg;

  localparam int CoordBits    = 13;
  localparam int ErrBits      = 14;
  localparam int CfgIndexBits = 3;

  typedef logic [CoordBits-1:0]      coord_t;
  typedef logic signed [ErrBits-1:0] err_t;

  // One axis stepper as it is kept in the state memory.
  typedef struct packed {
    err_t   err;
    coord_t src;
    coord_t rem;
    coord_t dst;
  } stepper_t;

  localparam int StepperBits = $bits(stepper_t);

  // Configuration as the engine sees it, extents already saturated.
  typedef struct packed {
    coord_t dest_left;
    coord_t dest_top;
    coord_t dest_width;
    coord_t dest_height;
    coord_t source_left;
    coord_t source_top;
    coord_t source_width;
    coord_t source_height;
  } cfg_t;

  typedef struct packed {
    logic   valid_res;
    coord_t dest_col;
    coord_t dest_row;
    coord_t source_col;
    coord_t source_row;
    logic   new_source_row;
    logic   row_last;
    logic   frame_last;
  } result_t;

  typedef enum logic [CfgIndexBits-1:0] {
    RegDestLeft     = 3'd0,
    RegDestTop      = 3'd1,
    RegDestWidth    = 3'd2,
    RegDestHeight   = 3'd3,
    RegSourceLeft   = 3'd4,
    RegSourceTop    = 3'd5,
    RegSourceWidth  = 3'd6,
    RegSourceHeight = 3'd7
  } cfg_reg_e;

  // State memory entries.
  localparam logic EntryCol = 1'b0;
  localparam logic EntryRow = 1'b1;

  // Starting error: half the destination extent when shrinking or equal,
  // the extent difference when enlarging.
  function automatic err_t err_init(input coord_t d, input coord_t s);
    coord_t diff;
    diff = d - s;
    if (d <= s) begin
      err_init = err_t'({1'b0, d >> 1});
    end else begin
      err_init = err_t'({1'b0, diff});
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/sbag_ram.sv =====
// ----------------------------------------------------------------------------
// sbag_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sbag_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/sbag_engine.sv =====
// ----------------------------------------------------------------------------
// sbag_engine
// Sequencer that reads, steps and writes back the two axis steppers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sbag_engine
  import sbag_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire logic    restart,
  input  wire cfg_t    cfg,
  output logic         idle,
  output result_t      res,
  output logic         res_pending,
  input  wire logic    res_load
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_RDCOL  = 10'b0000000010,
    S_RDROW  = 10'b0000000100,
    S_STEP   = 10'b0000001000,
    S_COLFIX = 10'b0000010000,
    S_ROWFIX = 10'b0000100000,
    S_WRROW  = 10'b0001000000,
    S_WRCOL  = 10'b0010000000,
    S_CALC   = 10'b0100000000,
    S_EMIT   = 10'b1000000000
  } state_t;

  state_t   state_r, state_nxt;
  stepper_t col_r, col_nxt;
  stepper_t row_r, row_nxt;
  logic     walking_r, walking_nxt;
  logic     have_row_r, have_row_nxt;
  coord_t   last_row_r, last_row_nxt;
  result_t  res_r, res_nxt;
  logic     first_col_r, first_col_nxt;

  logic                   mem_we;
  logic                   mem_waddr;
  logic [StepperBits-1:0] mem_wdata;
  logic                   mem_re;
  logic                   mem_raddr;
  logic [StepperBits-1:0] mem_rdata;

  logic   empty;
  coord_t sw_m1;
  coord_t sh_m1;
  coord_t sc;
  coord_t sr;
  logic   new_row;

  sbag_ram #(
    .WIDTH (StepperBits),
    .DEPTH (2)
  ) u_state_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign empty = (cfg.dest_width == '0) || (cfg.dest_height == '0) ||
                 (cfg.source_width == '0) || (cfg.source_height == '0);
  assign sw_m1 = cfg.source_width - coord_t'(1);
  assign sh_m1 = cfg.source_height - coord_t'(1);
  assign sc    = (col_r.src < sw_m1) ? col_r.src : sw_m1;
  assign sr    = (row_r.src < sh_m1) ? row_r.src : sh_m1;

  // The row flag is settled at hand-off, against the row last read.
  assign new_row = first_col_r && (!have_row_r || (res_r.source_row != last_row_r));

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    walking_nxt   = walking_r;
    have_row_nxt  = have_row_r;
    last_row_nxt  = last_row_r;
    res_nxt       = res_r;
    first_col_nxt = first_col_r;
    mem_we        = 1'b0;
    mem_waddr     = EntryCol;
    mem_wdata     = col_r;
    mem_re        = 1'b0;
    mem_raddr     = EntryCol;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (restart && !empty) begin
            row_nxt.err  = err_init(cfg.dest_height, cfg.source_height);
            row_nxt.src  = '0;
            row_nxt.dst  = '0;
            row_nxt.rem  = cfg.dest_height;
            col_nxt.err  = err_init(cfg.dest_width, cfg.source_width);
            col_nxt.src  = '0;
            col_nxt.dst  = '0;
            col_nxt.rem  = cfg.dest_width;
            have_row_nxt = 1'b0;
            walking_nxt  = 1'b1;
            state_nxt    = S_WRROW;
          end else if (restart || !walking_r || empty) begin
            if (empty) begin
              walking_nxt = 1'b0;
            end
            res_nxt       = '0;
            first_col_nxt = 1'b0;
            state_nxt     = S_EMIT;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = EntryCol;
            state_nxt = S_RDCOL;
          end
        end
      end
      S_RDCOL: begin
        col_nxt   = stepper_t'(mem_rdata);
        mem_re    = 1'b1;
        mem_raddr = EntryRow;
        state_nxt = S_RDROW;
      end
      S_RDROW: begin
        row_nxt   = stepper_t'(mem_rdata);
        state_nxt = S_STEP;
      end
      S_STEP: begin
        if (col_r.rem > coord_t'(1)) begin
          col_nxt.err = col_r.err - err_t'({1'b0, cfg.source_width});
          col_nxt.dst = col_r.dst + coord_t'(1);
          col_nxt.rem = col_r.rem - coord_t'(1);
          state_nxt   = S_COLFIX;
        end else if (row_r.rem <= coord_t'(1)) begin
          walking_nxt   = 1'b0;
          res_nxt       = '0;
          first_col_nxt = 1'b0;
          state_nxt     = S_EMIT;
        end else begin
          row_nxt.err = row_r.err - err_t'({1'b0, cfg.source_height});
          row_nxt.dst = row_r.dst + coord_t'(1);
          row_nxt.rem = row_r.rem - coord_t'(1);
          col_nxt.err = err_init(cfg.dest_width, cfg.source_width);
          col_nxt.src = '0;
          col_nxt.dst = '0;
          col_nxt.rem = cfg.dest_width;
          state_nxt   = S_ROWFIX;
        end
      end
      S_COLFIX: begin
        // One source column per cycle until the error is non-negative.
        if (col_r.err[ErrBits-1]) begin
          col_nxt.err = col_r.err + err_t'({1'b0, cfg.dest_width});
          col_nxt.src = col_r.src + coord_t'(1);
        end else begin
          state_nxt = S_WRCOL;
        end
      end
      S_ROWFIX: begin
        if (row_r.err[ErrBits-1]) begin
          row_nxt.err = row_r.err + err_t'({1'b0, cfg.dest_height});
          row_nxt.src = row_r.src + coord_t'(1);
        end else begin
          state_nxt = S_WRROW;
        end
      end
      S_WRROW: begin
        mem_we    = 1'b1;
        mem_waddr = EntryRow;
        mem_wdata = row_r;
        state_nxt = S_WRCOL;
      end
      S_WRCOL: begin
        mem_we    = 1'b1;
        mem_waddr = EntryCol;
        mem_wdata = col_r;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        res_nxt.valid_res      = 1'b1;
        res_nxt.dest_col       = cfg.dest_left + col_r.dst;
        res_nxt.dest_row       = cfg.dest_top + row_r.dst;
        res_nxt.source_col     = cfg.source_left + sc;
        res_nxt.source_row     = cfg.source_top + sr;
        res_nxt.new_source_row = 1'b0;
        res_nxt.row_last       = (col_r.rem <= coord_t'(1));
        res_nxt.frame_last     = (col_r.rem <= coord_t'(1)) && (row_r.rem <= coord_t'(1));
        first_col_nxt          = (col_r.dst == '0);
        state_nxt              = S_EMIT;
      end
      S_EMIT: begin
        if (res_load) begin
          if (res_r.valid_res && first_col_r) begin
            last_row_nxt = res_r.source_row;
            have_row_nxt = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      walking_r  <= 1'b0;
      have_row_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      walking_r  <= walking_nxt;
      have_row_r <= have_row_nxt;
    end
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    last_row_r  <= last_row_nxt;
    res_r       <= res_nxt;
    first_col_r <= first_col_nxt;
  end

  assign idle        = (state_r == S_IDLE);
  assign res_pending = (state_r == S_EMIT);

  always_comb begin
    res                = res_r;
    res.new_source_row = new_row;
  end

  `SBAG_ASSERT_NOW(a_load_only_in_emit, res_load, state_r == S_EMIT)
  `SBAG_ASSERT_NEXT(a_start_leaves_idle, start, state_r != S_IDLE)
  `SBAG_ASSERT_NOW(a_no_flag_without_result, res_pending && !res_r.valid_res,
                   !new_row)

endmodule

`default_nettype wire

// ===== sv/stretch_blit_address_generator_top.sv =====
// ----------------------------------------------------------------------------
// stretch_blit_address_generator_top
// Nearest-neighbor stretch address generator for a rectangle blit.
// ----------------------------------------------------------------------------
// Each input transaction either restarts the walk (in_restart = 1) or advances
// it by one destination pixel, and each produces exactly one output
// transaction that names the destination pixel and the source pixel feeding
// it. A restart writes back both steppers and forms the result. An advance
// reads both steppers, steps them, runs the error correction loop over the
// k source columns (or rows) skipped on that step and writes back what changed,
// where k is 1 or 0 when enlarging and about source/destination extent when
// shrinking. Its duration is set by the error correction loop, which adds the
// destination extent back once per cycle, and by the single write port of the
// two-entry state memory that holds the column and row steppers. A
// transaction that gives no pixel (idle, empty rectangle, past the end) skips
// the write back. The output register lets a finished result wait under
// out_stall while the block returns to accepting input.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module stretch_blit_address_generator_top
  import sbag_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,

  // Configuration write port.
  input  wire logic                    cfg_we,
  input  wire logic [CfgIndexBits-1:0] cfg_index,
  input  wire logic [CoordBits-1:0]    cfg_wdata,

  // Input channel.
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_restart,

  // Result channel.
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_valid_res,
  output logic [CoordBits-1:0]         out_dest_col,
  output logic [CoordBits-1:0]         out_dest_row,
  output logic [CoordBits-1:0]         out_source_col,
  output logic [CoordBits-1:0]         out_source_row,
  output logic                         out_new_source_row,
  output logic                         out_row_last,
  output logic                         out_frame_last
);

  // Extents above MAX_DIM are saturated; the compare is done wide enough
  // to hold any legal MAX_DIM.
  localparam logic [16:0] MaxDimW = 17'(MAX_DIM);

  coord_t dest_left_r, dest_top_r, dest_width_r, dest_height_r;
  coord_t source_left_r, source_top_r, source_width_r, source_height_r;

  cfg_t    cfg;
  logic    eng_idle;
  logic    start;
  result_t eng_res;
  logic    res_pending;
  logic    res_load;

  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  function automatic coord_t sat_extent(input coord_t v);
    if ({4'd0, v} > MaxDimW) begin
      sat_extent = MaxDimW[CoordBits-1:0];
    end else begin
      sat_extent = v;
    end
  endfunction

  // Configuration registers. Writes must arrive only while the block is idle; it does not check.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_left_r     <= '0;
      dest_top_r      <= '0;
      dest_width_r    <= '0;
      dest_height_r   <= '0;
      source_left_r   <= '0;
      source_top_r    <= '0;
      source_width_r  <= '0;
      source_height_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        RegDestLeft:     dest_left_r     <= cfg_wdata;
        RegDestTop:      dest_top_r      <= cfg_wdata;
        RegDestWidth:    dest_width_r    <= cfg_wdata;
        RegDestHeight:   dest_height_r   <= cfg_wdata;
        RegSourceLeft:   source_left_r   <= cfg_wdata;
        RegSourceTop:    source_top_r    <= cfg_wdata;
        RegSourceWidth:  source_width_r  <= cfg_wdata;
        RegSourceHeight: source_height_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.dest_left     = dest_left_r;
    cfg.dest_top      = dest_top_r;
    cfg.dest_width    = sat_extent(dest_width_r);
    cfg.dest_height   = sat_extent(dest_height_r);
    cfg.source_left   = source_left_r;
    cfg.source_top    = source_top_r;
    cfg.source_width  = sat_extent(source_width_r);
    cfg.source_height = sat_extent(source_height_r);
  end

  // The engine takes one transaction at a time and is ready only when idle.
  assign in_stall = !eng_idle;
  assign start    = in_valid && !in_stall;

  sbag_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .restart     (in_restart),
    .cfg         (cfg),
    .idle        (eng_idle),
    .res         (eng_res),
    .res_pending (res_pending),
    .res_load    (res_load)
  );

  // Output register: a finished result moves in when the slot is empty or
  // is being drained in the same cycle.
  assign res_load = res_pending && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_load) begin
      out_res_r <= eng_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_valid_res      = out_res_r.valid_res;
  assign out_dest_col       = out_res_r.dest_col;
  assign out_dest_row       = out_res_r.dest_row;
  assign out_source_col     = out_res_r.source_col;
  assign out_source_row     = out_res_r.source_row;
  assign out_new_source_row = out_res_r.new_source_row;
  assign out_row_last       = out_res_r.row_last;
  assign out_frame_last     = out_res_r.frame_last;

  `SBAG_ASSERT_NEXT(a_load_fills_output, res_load, out_valid_r)
  `SBAG_ASSERT_NOW(a_ready_means_drained, !in_stall, !res_pending)

endmodule

`default_nettype wire

// ===== verif/stretch_blit_address_generator_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stretch_blit_address_generator_top_tb
// Self-checking bench for the nearest-neighbor stretch address generator.
// ----------------------------------------------------------------------------
// A behavioral copy of the two Bresenham steppers predicts the pixel mapping
// for every accepted input transaction. Results are matched in order, field by
// field. The stimulus opens with hand-picked walks (idle advances, empty
// rectangles, shrinking, enlarging, coordinate wrap, saturated extents and
// register changes in the middle of a walk). Random walks follow under many
// register settings, with random idling on both channels, one long output
// hold-off and pauses that let the block drain completely.
// ----------------------------------------------------------------------------

import sbag_pkg::*;

localparam int MaxExtent = 4096;

// Predicts the pixel mappings and holds them until the block delivers them.
class pixel_map_scoreboard;
  coord_t  regs[8];
  int      col_err, row_err;
  coord_t  col_src, col_rem, col_dst;
  coord_t  row_src, row_rem, row_dst;
  coord_t  last_row;
  bit      have_row, walking;
  result_t pending_pixels[$];
  int      mismatches, n_checked, n_pixels, n_frames, n_new_rows, n_blank;

  function new();
    foreach (regs[i]) regs[i] = '0;
    col_err = 0;
    row_err = 0;
    col_src = '0;
    col_rem = '0;
    col_dst = '0;
    row_src = '0;
    row_rem = '0;
    row_dst = '0;
    last_row = '0;
    have_row = 1'b0;
    walking = 1'b0;
  endfunction

  function void write_reg(cfg_reg_e idx, coord_t value);
    regs[idx] = value;
  endfunction

  // Extents above the largest supported size behave as that size.
  function int span(cfg_reg_e idx);
    return (regs[idx] > MaxExtent) ? MaxExtent : int'(regs[idx]);
  endfunction

  function int initial_error(int d, int s);
    return (d <= s) ? (d >> 1) : (d - s);
  endfunction

  function void begin_row(int dw, int sw);
    col_err = initial_error(dw, sw);
    col_src = '0;
    col_dst = '0;
    col_rem = coord_t'(dw);
  endfunction

  // One stepper advance: take off the source extent, then add the
  // destination extent back until the error is non-negative again.
  function int step_error(int e, int d, int s, inout coord_t src);
    int n;
    e -= s;
    if (e < 0) begin
      n = (-e + d - 1) / d;
      e += n * d;
      src = src + coord_t'(n);
    end
    return e;
  endfunction

  // Notes one accepted input transaction and queues the mapping it yields.
  function result_t note_request(bit restart);
    int      dw, dh, sw, sh, sc, sr;
    bit      empty, mapped;
    result_t r;
    r = '0;
    mapped = 1'b0;
    dw = span(RegDestWidth);
    dh = span(RegDestHeight);
    sw = span(RegSourceWidth);
    sh = span(RegSourceHeight);
    empty = (dw == 0) || (dh == 0) || (sw == 0) || (sh == 0);
    if (restart) begin
      if (!empty) begin
        row_err = initial_error(dh, sh);
        row_src = '0;
        row_dst = '0;
        row_rem = coord_t'(dh);
        have_row = 1'b0;
        begin_row(dw, sw);
        walking = 1'b1;
        mapped = 1'b1;
      end else begin
        walking = 1'b0;
      end
    end else if (walking && !empty) begin
      if (col_rem > 1) begin
        col_err = step_error(col_err, dw, sw, col_src);
        col_dst = col_dst + 1'b1;
        col_rem = col_rem - 1'b1;
        mapped = 1'b1;
      end else if (row_rem > 1) begin
        row_err = step_error(row_err, dh, sh, row_src);
        row_dst = row_dst + 1'b1;
        row_rem = row_rem - 1'b1;
        begin_row(dw, sw);
        mapped = 1'b1;
      end else begin
        walking = 1'b0;
      end
    end else begin
      walking = 1'b0;
    end

    if (mapped) begin
      sc = (col_src < sw - 1) ? int'(col_src) : sw - 1;
      sr = (row_src < sh - 1) ? int'(row_src) : sh - 1;
      r.valid_res = 1'b1;
      r.dest_col = regs[RegDestLeft] + col_dst;
      r.dest_row = regs[RegDestTop] + row_dst;
      r.source_col = regs[RegSourceLeft] + coord_t'(sc);
      r.source_row = regs[RegSourceTop] + coord_t'(sr);
      if (col_dst == 0) begin
        r.new_source_row = !have_row || (r.source_row != last_row);
        last_row = r.source_row;
        have_row = 1'b1;
      end
      r.row_last = (col_rem <= 1);
      r.frame_last = (col_rem <= 1) && (row_rem <= 1);
    end
    pending_pixels.push_back(r);
    return r;
  endfunction

  function string show(result_t r);
    return $sformatf("valid=%0d dcol=%0d drow=%0d scol=%0d srow=%0d new=%0d rl=%0d fl=%0d",
                     r.valid_res, r.dest_col, r.dest_row, r.source_col,
                     r.source_row, r.new_source_row, r.row_last, r.frame_last);
  endfunction

  function void report(string what);
    mismatches++;
    if (mismatches <= 10) $display("ERROR at %0t: %s", $time, what);
  endfunction

  function void check_pixel(result_t got);
    result_t exp;
    string   diff;
    n_checked++;
    if (pending_pixels.size() == 0) begin
      report({"result with nothing expected: ", show(got)});
    end else begin
      exp = pending_pixels.pop_front();
      diff = "";
      if (got.valid_res !== exp.valid_res) diff = {diff, " valid_res"};
      if (got.dest_col !== exp.dest_col) diff = {diff, " dest_col"};
      if (got.dest_row !== exp.dest_row) diff = {diff, " dest_row"};
      if (got.source_col !== exp.source_col) diff = {diff, " source_col"};
      if (got.source_row !== exp.source_row) diff = {diff, " source_row"};
      if (got.new_source_row !== exp.new_source_row) diff = {diff, " new_source_row"};
      if (got.row_last !== exp.row_last) diff = {diff, " row_last"};
      if (got.frame_last !== exp.frame_last) diff = {diff, " frame_last"};
      if (diff != "") begin
        report($sformatf("mismatch in%s: expected %s, got %s", diff, show(exp), show(got)));
      end else if (exp.valid_res) begin
        n_pixels++;
        if (exp.frame_last) n_frames++;
        if (exp.new_source_row) n_new_rows++;
      end else begin
        n_blank++;
      end
    end
  endfunction
endclass

module stretch_blit_address_generator_top_tb
  import sbag_pkg::*;
;
  // A single step can skip about two thousand source pixels at the largest
  // extents, so the limit covers every transaction taking such a step under
  // the longest stalls on both sides, several times over.
  localparam int CycleLimit = 20000000;
  localparam int ItemTarget = 1400;
  localparam int TailCycles = 50;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CfgIndexBits-1:0] cfg_index;
  logic [CoordBits-1:0]    cfg_wdata;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_restart;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_valid_res;
  logic [CoordBits-1:0]    out_dest_col;
  logic [CoordBits-1:0]    out_dest_row;
  logic [CoordBits-1:0]    out_source_col;
  logic [CoordBits-1:0]    out_source_row;
  logic                    out_new_source_row;
  logic                    out_row_last;
  logic                    out_frame_last;

  pixel_map_scoreboard sb;

  // Register values that the next call of program_regs writes.
  int unsigned next_regs[8];

  // Idling switches for the two sides, and a request for a long output
  // hold-off that the result sink counts down on its own.
  bit tx_idling;
  bit rx_idling;
  int hold_request;
  int items_sent;
  int settings;

  stretch_blit_address_generator_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_restart         (in_restart),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_valid_res      (out_valid_res),
    .out_dest_col       (out_dest_col),
    .out_dest_row       (out_dest_row),
    .out_source_col     (out_source_col),
    .out_source_row     (out_source_row),
    .out_new_source_row (out_new_source_row),
    .out_row_last       (out_row_last),
    .out_frame_last     (out_frame_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The watchdog ends a run that hangs, for example when the block stops
  // accepting input transactions or never delivers an expected result.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("stretch_blit_address_generator_top_tb NOT OK");
    $finish;
  end

  // Result sink. Output transactions are taken at the rising edge, where the
  // block's outputs still hold the values from before the edge. The sink also
  // owns out_stall: random stall bursts while rx_idling is set, and one long
  // hold-off when the stimulus asks for it.
  initial begin : result_sink
    int      stall_left;
    int      hold_left;
    result_t got;
    out_stall = 1'b0;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.valid_res = out_valid_res;
        got.dest_col = out_dest_col;
        got.dest_row = out_dest_row;
        got.source_col = out_source_col;
        got.source_row = out_source_row;
        got.new_source_row = out_new_source_row;
        got.row_last = out_row_last;
        got.frame_last = out_frame_last;
        sb.check_pixel(got);
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (rx_idling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one input transaction and returns once the block has taken it.
  // in_valid is left high so that back-to-back transactions need no gap.
  task automatic send_item(input bit restart, output result_t predicted);
    in_valid <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = sb.note_request(restart);
    items_sent++;
  endtask

  // A random burst of idle cycles on the input side.
  task automatic pace();
    if (tx_idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Holds the input side off until every expected result has come back.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_pixels.size() != 0);
  endtask

  // Writes the selected registers from next_regs once the block is idle.
  // The write enable is lowered only after the last write.
  task automatic program_regs(input bit [7:0] which);
    pause_until_drained();
    for (int i = 0; i < 8; i++) begin
      if (which[i]) begin
        cfg_we <= 1'b1;
        cfg_index <= cfg_reg_e'(i);
        cfg_wdata <= coord_t'(next_regs[i]);
        @(posedge clk);
        sb.write_reg(cfg_reg_e'(i), coord_t'(next_regs[i]));
      end
    end
    cfg_we <= 1'b0;
  endtask

  task automatic stage_regs(input int unsigned dl, input int unsigned dt,
                            input int unsigned dw, input int unsigned dh,
                            input int unsigned sl, input int unsigned st,
                            input int unsigned sw, input int unsigned sh);
    next_regs[RegDestLeft] = dl;
    next_regs[RegDestTop] = dt;
    next_regs[RegDestWidth] = dw;
    next_regs[RegDestHeight] = dh;
    next_regs[RegSourceLeft] = sl;
    next_regs[RegSourceTop] = st;
    next_regs[RegSourceWidth] = sw;
    next_regs[RegSourceHeight] = sh;
  endtask

  // Walks the rectangle until the last pixel, until the block reports no
  // pixel, or until the step budget is used up. Starting without a restart
  // continues whatever walk the block already has in progress.
  task automatic walk(input bit restart_first, input int cap);
    result_t p;
    int      steps;
    pace();
    send_item(restart_first, p);
    steps = 1;
    while (p.valid_res && !p.frame_last && steps < cap) begin
      if ($urandom_range(0, 99) < 2) pause_until_drained();
      pace();
      send_item(1'b0, p);
      steps++;
    end
  endtask

  // Extents by kind of setting: mostly small rectangles, then strong
  // shrinking, extents past the saturation point, and fully random values.
  function automatic int pick_extent(int kind, bit is_source);
    if (kind < 80) return $urandom_range(1, 10);
    if (kind < 90) return is_source ? $urandom_range(16, 300) : $urandom_range(1, 5);
    if (kind < 95) return $urandom_range(0, 1) ? $urandom_range(4097, 8191) : $urandom_range(1, 8);
    return $urandom_range(0, 8191);
  endfunction

  initial begin : stimulus
    result_t    p;
    int         kind;
    int         walks;
    int         cap_max;
    int         cap;
    bit         carry_on;
    bit [7:0]   which;
    cfg_reg_e   gone;

    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_restart = 1'b0;
    tx_idling = 1'b1;
    rx_idling = 1'b1;
    hold_request = 0;
    items_sent = 0;
    settings = 0;
    foreach (next_regs[i]) next_regs[i] = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Out of reset every extent is zero: an advance while idle and a restart
    // of an empty rectangle both give no pixel.
    send_item(1'b0, p);
    send_item(1'b1, p);

    // Shrinking 5x4 onto 3x2, then one advance past the end and one more
    // while idle.
    stage_regs(0, 0, 3, 2, 0, 0, 5, 4);
    program_regs(8'hFF);
    settings++;
    walk(1'b1, 20);
    send_item(1'b0, p);
    send_item(1'b0, p);

    // Enlarging 2x1 onto 3x2 with origins at the top of the coordinate
    // range, so that both destination and source coordinates wrap.
    stage_regs(8190, 8191, 3, 2, 8191, 8190, 2, 1);
    program_regs(8'hFF);
    settings++;
    walk(1'b1, 20);
    send_item(1'b0, p);

    // Extents above the maximum saturate; all-ones values in four of the fields.
    stage_regs(8191, 0, 8191, 4097, 0, 8191, 4096, 8191);
    program_regs(8'hFF);
    settings++;
    walk(1'b1, 3);

    // Narrow the source in the middle of the walk: the next steps use the
    // new values with the stepper state as it stands.
    next_regs[RegSourceLeft] = 8191;
    next_regs[RegSourceWidth] = 1;
    which = '0;
    which[RegSourceLeft] = 1'b1;
    which[RegSourceWidth] = 1'b1;
    program_regs(which);
    settings++;
    send_item(1'b0, p);
    send_item(1'b0, p);

    // A zero height in the middle of a walk ends it with no pixel.
    next_regs[RegDestHeight] = 0;
    which = '0;
    which[RegDestHeight] = 1'b1;
    program_regs(which);
    settings++;
    send_item(1'b0, p);

    // Back pressure: the sink holds off for a long stretch while the source
    // keeps offering transactions, so the block fills up and stalls its
    // input. Half way through the walk the source pauses until every result
    // is back, then carries on with the same walk.
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    stage_regs($urandom_range(0, 8191), $urandom_range(0, 8191), 7, 5,
               $urandom_range(0, 8191), $urandom_range(0, 8191), 3, 6);
    program_regs(8'hFF);
    settings++;
    hold_request = 400;
    walk(1'b1, 18);
    pause_until_drained();
    walk(1'b0, 100);

    // Random walks. Each round picks a register setting, sometimes writes
    // only part of it and sometimes keeps the walk already in progress.
    // Most transactions belong to complete walks; abandoned walks and
    // advances past the end add noise. The last stretch runs without idling.
    while (items_sent < ItemTarget) begin
      if (items_sent > ItemTarget - 200) begin
        tx_idling = 1'b0;
        rx_idling = 1'b0;
      end else begin
        tx_idling = ($urandom_range(0, 3) != 0);
        rx_idling = ($urandom_range(0, 3) != 0);
      end
      kind = $urandom_range(0, 99);
      next_regs[RegDestLeft] = $urandom_range(0, 8191);
      next_regs[RegDestTop] = $urandom_range(0, 8191);
      next_regs[RegSourceLeft] = $urandom_range(0, 8191);
      next_regs[RegSourceTop] = $urandom_range(0, 8191);
      next_regs[RegDestWidth] = pick_extent(kind, 1'b0);
      next_regs[RegDestHeight] = pick_extent(kind, 1'b0);
      next_regs[RegSourceWidth] = pick_extent(kind, 1'b1);
      next_regs[RegSourceHeight] = pick_extent(kind, 1'b1);
      if (kind >= 70 && kind < 80) begin
        case ($urandom_range(0, 3))
          0: gone = RegDestWidth;
          1: gone = RegDestHeight;
          2: gone = RegSourceWidth;
          default: gone = RegSourceHeight;
        endcase
        next_regs[gone] = 0;
      end
      which = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hFF;
      carry_on = ($urandom_range(0, 4) == 0);
      program_regs(which);
      settings++;

      cap_max = (kind < 90) ? 150 : 8;
      walks = (kind < 90) ? $urandom_range(1, 3) : 1;
      for (int w = 0; w < walks; w++) begin
        cap = ($urandom_range(0, 6) == 0) ? $urandom_range(1, cap_max) : cap_max;
        walk(!(w == 0 && carry_on), cap);
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 2)) begin
            pace();
            send_item(1'b0, p);
          end
        end
      end
    end

    // Let every expected result come back, then watch for strays.
    pause_until_drained();
    repeat (TailCycles) @(posedge clk);

    $display("Covered %0d input transactions under %0d register settings.",
             items_sent, settings);
    $display("Checked %0d results: %0d pixels, %0d frame ends, %0d new source rows, %0d blank.",
             sb.n_checked, sb.n_pixels, sb.n_frames, sb.n_new_rows, sb.n_blank);
    if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
      $display("stretch_blit_address_generator_top_tb OK");
    end else begin
      $display("stretch_blit_address_generator_top_tb NOT OK");
    end
    $finish;
  end

endmodule
